### rtl/core/i8dr_pkg.sv
// shared constants and types for the int8 dot product requantizer
`default_nettype none
package i8dr_pkg;

    localparam int LANES      = 8;
    localparam int ACC_WIDTH  = 32;
    localparam int MULT_W     = 32;
    localparam int BIAS_W     = 48;
    localparam int FRAC_BITS  = 24;
    localparam int CODE_W     = 8;
    localparam int LANE_W     = 8;
    localparam int LPROD_W    = 2 * LANE_W;
    localparam int CHUNK_W    = LPROD_W + $clog2(LANES);
    localparam int PROD_W     = ACC_WIDTH + MULT_W;
    localparam int CAP_SHIFT  = 62;
    localparam int CAP_W      = (PROD_W > CAP_SHIFT + 1) ? PROD_W : CAP_SHIFT + 1;
    localparam int VAL_W      = 64;
    localparam int CODE_MAX   = 127;
    localparam int CODE_MINM  = 128;

    // stream field layout, lowest bits first
    localparam int ACT_LSB    = 0;
    localparam int WGT_LSB    = LANES * 0 + 64;
    localparam int MULT_LSB   = 128;
    localparam int BIAS_LSB   = MULT_LSB + MULT_W;
    localparam int IN_DATA_W  = BIAS_LSB + BIAS_W;
    localparam int OUT_USER_W = 2;

    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] acc;
        logic                        wrap;
        logic [MULT_W-1:0]           mult;
        logic signed [BIAS_W-1:0]    bias;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_xfer;

    typedef struct packed {
        logic [QCW-1:0] count;
    } t_q_status;

endpackage
`default_nettype wire

### rtl/core/i8dr_front.sv
// front end: takes chunks, forms lane products and keeps the running sum
`default_nettype none
module i8dr_front
    import i8dr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [64-1:0]         i_act,
    input  wire logic [64-1:0]         i_wgt,
    input  wire logic                  i_last,
    input  wire logic [MULT_W-1:0]     i_mult,
    input  wire logic [BIAS_W-1:0]     i_bias,
    input  wire t_q_status             i_q_status,
    output t_job_xfer                  o_push
);

    logic                        r_s1_valid;
    logic signed [CHUNK_W-1:0]   r_s1_chunk;
    logic                        r_s1_last;
    logic [MULT_W-1:0]           r_s1_mult;
    logic signed [BIAS_W-1:0]    r_s1_bias;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic                        r_wrap;

    logic signed [CHUNK_W-1:0]   n_chunk;
    logic signed [ACC_WIDTH:0]   sum;
    logic                        ovf;
    logic [QCW:0]                used;
    logic                        accept;

    // one slot is held back for the chunk still in the first stage
    assign used    = (QCW+1)'(i_q_status.count) + (QCW+1)'(r_s1_valid);
    assign o_ready = used < (QCW+1)'(QDEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic signed [LPROD_W-1:0] lane_prod;
        n_chunk = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_prod = $signed(i_act[LANE_W*i +: LANE_W]) * $signed(i_wgt[LANE_W*i +: LANE_W]);
            n_chunk   = n_chunk + CHUNK_W'(lane_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_chunk <= n_chunk;
            r_s1_last  <= i_last;
            r_s1_mult  <= i_mult;
            r_s1_bias  <= $signed(i_bias);
        end
    end

    assign sum = (ACC_WIDTH+1)'(r_acc) + (ACC_WIDTH+1)'(r_s1_chunk);
    assign ovf = sum[ACC_WIDTH] ^ sum[ACC_WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_wrap <= 1'b0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_acc  <= '0;
                r_wrap <= 1'b0;
            end else begin
                r_acc  <= sum[ACC_WIDTH-1:0];
                r_wrap <= r_wrap | ovf;
            end
        end
    end

    always_comb begin
        o_push.valid    = r_s1_valid && r_s1_last;
        o_push.job.acc  = sum[ACC_WIDTH-1:0];
        o_push.job.wrap = r_wrap | ovf;
        o_push.job.mult = r_s1_mult;
        o_push.job.bias = r_s1_bias;
    end

endmodule
`default_nettype wire

### rtl/core/i8dr_queue.sv
// short job queue between the accumulate front and the requantize back
`default_nettype none
module i8dr_queue
    import i8dr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_xfer i_push,
    input  wire logic      i_pop,
    output t_job_xfer      o_head,
    output t_q_status      o_status
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid   = r_count != '0;
    assign o_head.job     = r_mem[r_rd_ptr];
    assign o_status.count = r_count;

endmodule
`default_nettype wire

### rtl/core/i8dr_back.sv
// back end: scale, bias, relu, round and clamp one finished sum
`default_nettype none
module i8dr_back
    import i8dr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_relu,
    input  wire t_job_xfer         i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CODE_W-1:0]      o_code,
    output logic                   o_clamped,
    output logic                   o_wrapped
);

    logic                     r_relu_enable;

    logic                     r_b1_valid;
    logic                     r_b1_neg;
    logic [ACC_WIDTH-1:0]     r_b1_mag;
    logic [MULT_W-1:0]        r_b1_mult;
    logic signed [BIAS_W-1:0] r_b1_bias;
    logic                     r_b1_wrap;

    logic                     r_b2_valid;
    logic                     r_b2_neg;
    logic [PROD_W-1:0]        r_b2_prod;
    logic signed [BIAS_W-1:0] r_b2_bias;
    logic                     r_b2_wrap;

    logic                     r_b3_valid;
    logic signed [VAL_W-1:0]  r_b3_val;
    logic                     r_b3_wrap;

    logic                     r_b4_valid;
    logic                     r_b4_neg;
    logic [VAL_W-1:0]         r_b4_mag;
    logic                     r_b4_wrap;

    logic                     r_out_valid;
    logic [CODE_W-1:0]        r_out_code;
    logic                     r_out_clamped;
    logic                     r_out_wrap;

    logic                     advance;
    logic                     head_neg;
    logic [CAP_W-1:0]         prod_ext;
    logic [CAP_W-1:0]         capped;
    logic signed [VAL_W-1:0]  n_val;
    logic signed [VAL_W-1:0]  relu_val;
    logic [VAL_W-1:0]         rnd;
    logic [VAL_W-1:0]         r_int;
    logic [CODE_W-1:0]        n_code;
    logic                     n_clamped;

    localparam logic [CAP_W-1:0] CAP_VAL = CAP_W'(1) << CAP_SHIFT;

    // the whole pipe holds while the output register waits
    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relu_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_relu_enable <= i_cfg_relu;
        end
    end

    assign head_neg = i_head.job.acc[ACC_WIDTH-1];
    assign prod_ext = CAP_W'(r_b2_prod);
    assign capped   = (prod_ext > CAP_VAL) ? CAP_VAL : prod_ext;

    always_comb begin
        n_val = r_b2_neg ? -$signed(VAL_W'(capped)) : $signed(VAL_W'(capped));
        n_val = n_val + VAL_W'(r_b2_bias);
    end

    assign relu_val = (r_relu_enable && r_b3_val[VAL_W-1]) ? '0 : r_b3_val;

    assign rnd   = r_b4_mag + (VAL_W'(1) << (FRAC_BITS - 1));
    assign r_int = rnd >> FRAC_BITS;

    always_comb begin
        if (r_b4_neg) begin
            n_clamped = r_int > VAL_W'(CODE_MINM);
            n_code    = n_clamped ? CODE_W'(CODE_MINM) : CODE_W'(-r_int);
        end else begin
            n_clamped = r_int > VAL_W'(CODE_MAX);
            n_code    = n_clamped ? CODE_W'(CODE_MAX) : CODE_W'(r_int);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_b4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_b1_valid  <= i_head.valid;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_b4_valid  <= r_b3_valid;
            r_out_valid <= r_b4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b1_neg      <= head_neg;
            r_b1_mag      <= head_neg ? ACC_WIDTH'(-i_head.job.acc) : i_head.job.acc;
            r_b1_mult     <= i_head.job.mult;
            r_b1_bias     <= i_head.job.bias;
            r_b1_wrap     <= i_head.job.wrap;

            r_b2_neg      <= r_b1_neg;
            r_b2_prod     <= PROD_W'(r_b1_mag) * PROD_W'(r_b1_mult);
            r_b2_bias     <= r_b1_bias;
            r_b2_wrap     <= r_b1_wrap;

            r_b3_val      <= n_val;
            r_b3_wrap     <= r_b2_wrap;

            r_b4_neg      <= relu_val[VAL_W-1];
            r_b4_mag      <= relu_val[VAL_W-1] ? VAL_W'(-relu_val) : relu_val;
            r_b4_wrap     <= r_b3_wrap;

            r_out_code    <= n_code;
            r_out_clamped <= n_clamped;
            r_out_wrap    <= r_b4_wrap;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_code    = r_out_code;
    assign o_clamped = r_out_clamped;
    assign o_wrapped = r_out_wrap;

endmodule
`default_nettype wire

### rtl/core/int8_dot_requantize.sv
// top level: int8 dot product with per-channel requantization to int8
// result path: front stage, job queue, back stages b1 to b4, output register
// throughput: one chunk per cycle; the four-entry job queue plus the chunk in
// the front stage set when o_s_tready drops under output backpressure
// reset: synchronous, active low; clears the sum, wrap flag, relu_enable,
// queue pointers and all valid flags
`default_nettype none
module int8_dot_requantize
    import i8dr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // act_lanes, weight_lanes, out_multiplier, bias_fixed
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_s_tlast,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // out_code
    output logic [CODE_W-1:0]          o_m_tdata,
    // clamped, acc_wrapped
    output logic [OUT_USER_W-1:0]      o_m_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data
);

    t_job_xfer push;
    t_job_xfer head;
    t_q_status q_status;
    logic      pop;
    logic      clamped;
    logic      wrapped;

    assign o_cfg_ready = 1'b1;

    i8dr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_act      (i_s_tdata[ACT_LSB +: 64]),
        .i_wgt      (i_s_tdata[WGT_LSB +: 64]),
        .i_last     (i_s_tlast),
        .i_mult     (i_s_tdata[MULT_LSB +: MULT_W]),
        .i_bias     (i_s_tdata[BIAS_LSB +: BIAS_W]),
        .i_q_status (q_status),
        .o_push     (push)
    );

    i8dr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    i8dr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_relu  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_code      (o_m_tdata),
        .o_clamped   (clamped),
        .o_wrapped   (wrapped)
    );

    assign o_m_tuser = {wrapped, clamped};

endmodule
`default_nettype wire

### rtl/core/i8dr_checker.sv
// port-level checks for the int8 dot product requantizer
`default_nettype none
module i8dr_checker
    import i8dr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [CODE_W-1:0]     o_m_tdata,
    input  wire logic [OUT_USER_W-1:0] o_m_tuser,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  o_cfg_ready,
    input  wire logic                  i_cfg_data
);

    logic r_relu_seen;

    // mirror of relu_enable from config transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relu_seen <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_relu_seen <= i_cfg_data;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_clamp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata == 8'h80) || (o_m_tdata == 8'h7f))
        else $error("clamped result is not at an int8 limit");

    a_relu_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_relu_seen |-> !o_m_tdata[CODE_W-1])
        else $error("negative code with relu enabled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind int8_dot_requantize i8dr_checker u_i8dr_checker (.*);
`default_nettype wire

### test/int8_dot_requantize_tb.sv
// self-checking testbench for int8_dot_requantize: queued stream stimulus, in-order result predictor
`timescale 1ns / 1ps
`default_nettype none
module int8_dot_requantize_tb;
    import i8dr_pkg::*;

    localparam int       IDLE_PCT       = 26;
    localparam int       SETTLE_CYCLES  = 12;
    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       MAX_PRINTS     = 50;
    localparam longint   ONE_Q          = 64'sd16777216;
    localparam longint   HALF_Q         = 64'sd8388608;
    localparam logic [63:0] PROD_SAT    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LANES_MIN   = 64'h8080_8080_8080_8080;
    localparam logic [63:0] LANES_MAX   = 64'h7f7f_7f7f_7f7f_7f7f;

    typedef struct {
        logic [63:0]        act;
        logic [63:0]        wgt;
        logic               last;
        logic [MULT_W-1:0]  mult;
        logic signed [BIAS_W-1:0] bias;
    } t_chunk;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              clamped;
        logic              wrapped;
    } t_requant_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CODE_W-1:0]    m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;

    t_chunk          chunk_queue[$];
    t_requant_result expected_codes[$];
    t_chunk          cur_chunk;
    t_requant_result seen_exp;

    // predictor state
    longint signed acc_model  = 0;
    logic          wrap_model = 1'b0;
    logic          relu_model = 1'b0;

    bit calm = 1'b0;
    int mismatches = 0;
    int stall_cycles = 0;

    int8_dot_requantize DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int gap_pct();
        return calm ? 0 : IDLE_PCT;
    endfunction

    // accumulate one chunk and, on the last one, queue the requantized code
    function automatic void mac_and_requantize(input t_chunk c);
        longint signed   chunk_sum;
        longint signed   total;
        longint signed   a_code;
        longint signed   w_code;
        longint signed   v;
        logic [63:0]     mag;
        logic [63:0]     prod;
        logic [63:0]     vmag;
        logic [63:0]     rounded;
        logic [63:0]     signed_r;
        logic            neg;
        int              lane;
        t_requant_result res;
        chunk_sum = 0;
        for (lane = 0; lane < LANES; lane++) begin
            a_code = $signed(c.act[LANE_W*lane +: LANE_W]);
            w_code = $signed(c.wgt[LANE_W*lane +: LANE_W]);
            chunk_sum += a_code * w_code;
        end
        total = acc_model + chunk_sum;
        if (total > 64'sd2147483647 || total < -64'sd2147483648) begin
            wrap_model = 1'b1;
            total = $signed(total[ACC_WIDTH-1:0]);
        end
        acc_model = total;
        if (!c.last) return;

        neg = acc_model < 0;
        mag = neg ? -acc_model : acc_model;
        prod = mag * {32'd0, c.mult};
        if (prod > PROD_SAT) prod = PROD_SAT;
        v = neg ? -longint'(prod) : longint'(prod);
        v = v + c.bias;
        if (relu_model && v < 0) v = 0;

        neg = v < 0;
        vmag = neg ? -v : v;
        rounded = (vmag + HALF_Q) >> FRAC_BITS;
        res.clamped = 1'b0;
        if (neg && rounded > CODE_MINM) begin
            rounded = CODE_MINM;
            res.clamped = 1'b1;
        end else if (!neg && rounded > CODE_MAX) begin
            rounded = CODE_MAX;
            res.clamped = 1'b1;
        end
        signed_r = neg ? -rounded : rounded;
        res.code = signed_r[CODE_W-1:0];
        res.wrapped = wrap_model;
        expected_codes.push_back(res);
        acc_model = 0;
        wrap_model = 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                mac_and_requantize(cur_chunk);
            end
            if (!s_tvalid || s_tready) begin
                if (chunk_queue.size() != 0 && $urandom_range(99) >= gap_pct()) begin
                    cur_chunk = chunk_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_chunk.bias, cur_chunk.mult, cur_chunk.wgt, cur_chunk.act};
                    s_tlast  <= cur_chunk.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code %h", m_tdata));
                end else begin
                    seen_exp = expected_codes.pop_front();
                    if (m_tdata !== seen_exp.code)
                        report_mismatch($sformatf("out_code %h, want %h",
                                                  m_tdata, seen_exp.code));
                    if (m_tuser[0] !== seen_exp.clamped)
                        report_mismatch($sformatf("clamped %b, want %b",
                                                  m_tuser[0], seen_exp.clamped));
                    if (m_tuser[1] !== seen_exp.wrapped)
                        report_mismatch($sformatf("acc_wrapped %b, want %b",
                                                  m_tuser[1], seen_exp.wrapped));
                end
            end
            m_tready <= ($urandom_range(99) >= gap_pct());
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic t_chunk make_chunk(input logic [63:0] act, input logic [63:0] wgt,
                                          input logic last, input logic [MULT_W-1:0] mult,
                                          input logic signed [BIAS_W-1:0] bias);
        t_chunk c;
        c.act  = act;
        c.wgt  = wgt;
        c.last = last;
        c.mult = mult;
        c.bias = bias;
        return c;
    endfunction

    function automatic logic [63:0] rand_lanes();
        logic [63:0] w;
        int          lane;
        w = {$urandom, $urandom};
        case ($urandom_range(3))
            1: begin
                for (lane = 0; lane < LANES; lane++)
                    w[LANE_W*lane +: LANE_W] = 8'($urandom_range(8)) - 8'd4;
            end
            2: begin
                for (lane = 0; lane < LANES; lane++) begin
                    case ($urandom_range(3))
                        0: w[LANE_W*lane +: LANE_W] = 8'h80;
                        1: w[LANE_W*lane +: LANE_W] = 8'h7f;
                        2: w[LANE_W*lane +: LANE_W] = 8'h00;
                        default: w[LANE_W*lane +: LANE_W] = 8'hff;
                    endcase
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    // mostly scales that keep short sums inside the int8 range
    function automatic logic [MULT_W-1:0] rand_mult();
        logic [MULT_W-1:0] m;
        m = $urandom;
        if ($urandom_range(3) == 0) return m;
        return m >> $urandom_range(12, 22);
    endfunction

    function automatic logic signed [BIAS_W-1:0] rand_bias();
        logic signed [BIAS_W-1:0] b;
        b = BIAS_W'({$urandom, $urandom});
        if ($urandom_range(3) == 0) return b;
        return b >>> $urandom_range(18, 28);
    endfunction

    task automatic queue_random_dot(input int len);
        int k;
        for (k = 0; k < len; k++)
            chunk_queue.push_back(make_chunk(rand_lanes(), rand_lanes(), k == len - 1,
                                             rand_mult(), rand_bias()));
    endtask

    task automatic queue_random_phase(input int n_items);
        int queued;
        int len;
        queued = 0;
        while (queued < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            queue_random_dot(len);
            queued += len;
        end
    endtask

    task automatic queue_saturating_run(input int n_chunks, input logic [63:0] wgt,
                                        input logic [MULT_W-1:0] last_mult);
        int k;
        for (k = 0; k < n_chunks - 1; k++)
            chunk_queue.push_back(make_chunk(LANES_MIN, wgt, 1'b0, rand_mult(), rand_bias()));
        chunk_queue.push_back(make_chunk(LANES_MIN, wgt, 1'b1, last_mult, rand_bias()));
    endtask

    // pause the sender until every expected result is back and the pipe is empty
    task automatic wait_drained();
        @(negedge clk);
        while (chunk_queue.size() != 0 || s_tvalid || expected_codes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_relu(input logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        relu_model = val;
        @(negedge clk);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, relu off
        write_relu(1'b0);
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, '0));
        chunk_queue.push_back(make_chunk(LANES_MIN, LANES_MIN, 1'b1, '1, 48'h7fff_ffff_ffff));
        chunk_queue.push_back(make_chunk(LANES_MIN, LANES_MAX, 1'b1, '1, 48'h8000_0000_0000));
        // exact minus 128 is not a clamp, minus 128.5 is
        chunk_queue.push_back(make_chunk('0, '1, 1'b1, '1, 48'(-128 * ONE_Q)));
        chunk_queue.push_back(make_chunk('0, '1, 1'b1, '1, 48'(-128 * ONE_Q - HALF_Q)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(-127 * ONE_Q - HALF_Q)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(127 * ONE_Q + HALF_Q)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(127 * ONE_Q + HALF_Q - 1)));
        // rounding ties go away from zero
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(HALF_Q)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(HALF_Q - 1)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(-HALF_Q)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(-HALF_Q + 1)));
        chunk_queue.push_back(make_chunk('1, 64'h0101_0101_0101_0101, 1'b1, 32'h0100_0000, '0));
        chunk_queue.push_back(make_chunk(64'h7f80_7f80_7f80_7f80, LANES_MAX, 1'b0, '0, '0));
        chunk_queue.push_back(make_chunk(rand_lanes(), rand_lanes(), 1'b0, '0, '0));
        chunk_queue.push_back(make_chunk(rand_lanes(), rand_lanes(), 1'b1, 32'h0000_0100,
                                         rand_bias()));
        chunk_queue.push_back(make_chunk(LANES_MAX, LANES_MAX, 1'b1, '0, 48'(-3 * ONE_Q)));
        wait_drained();

        // directed, relu on
        write_relu(1'b1);
        chunk_queue.push_back(make_chunk(LANES_MIN, LANES_MAX, 1'b1, 32'h0100_0000, '0));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(-HALF_Q)));
        chunk_queue.push_back(make_chunk('0, '0, 1'b1, '0, 48'(5 * ONE_Q + HALF_Q)));
        chunk_queue.push_back(make_chunk(LANES_MIN, LANES_MIN, 1'b1, '1, '0));
        chunk_queue.push_back(make_chunk(LANES_MIN, LANES_MAX, 1'b1, '1, 48'h7fff_ffff_ffff));
        wait_drained();

        // back-to-back runs at the lane extremes, no idling on either side
        write_relu(1'b0);
        calm = 1'b1;
        queue_saturating_run(40, LANES_MIN, '1);
        queue_saturating_run(44, LANES_MIN, rand_mult());
        queue_saturating_run(40, LANES_MAX, rand_mult());
        queue_random_dot(3);
        wait_drained();
        calm = 1'b0;

        write_relu(1'b1);
        queue_random_phase(150);
        wait_drained();
        write_relu(1'b0);
        queue_random_phase(75);
        wait_drained();
        queue_random_phase(75);
        wait_drained();
        write_relu(1'b1);
        queue_random_phase(150);
        wait_drained();
        write_relu(1'b0);
        queue_random_phase(150);
        wait_drained();
        write_relu(1'b1);
        queue_random_phase(150);
        wait_drained();
        write_relu(1'b0);
        queue_random_phase(50);
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
